FILE: hdl/cnpg_pkg.sv
// Shared types, constants and arithmetic helpers of the cloud noise pixel generator.
package cnpg_pkg;

   localparam int COORD_WIDTH = 12;
   localparam int COLOR_WIDTH = 24;
   localparam int FREQ_WIDTH  = 24;
   localparam int PERS_WIDTH  = 16;
   localparam int COUNT_WIDTH = 4;
   localparam int PROD_WIDTH  = COORD_WIDTH + FREQ_WIDTH;
   localparam int ACC_WIDTH   = 40;
   localparam int T_WIDTH     = 31;

   localparam logic [31:0] HASH_MUL_A = 32'd15731;
   localparam logic [31:0] HASH_ADD_B = 32'd789221;
   localparam logic [31:0] HASH_ADD_C = 32'd1376312589;
   localparam logic [T_WIDTH-1:0] ONE_Q30 = T_WIDTH'(1 << 30);
   localparam logic signed [ACC_WIDTH-1:0] HALF_Q30 = ACC_WIDTH'(1 << 29);
   localparam logic [15:0] AMP_ONE = 16'd32768;

   typedef enum logic [2:0] {
      REG_FIRST_COLOR    = 3'd0,
      REG_SECOND_COLOR   = 3'd1,
      REG_BASE_FREQUENCY = 3'd2,
      REG_PERSISTENCE    = 3'd3,
      REG_OCTAVE_COUNT   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [COORD_WIDTH-1:0] column;
      logic [COORD_WIDTH-1:0] row;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rsp_payload_type;

   // State carried from one octave section to the next.
   typedef struct packed {
      logic [PROD_WIDTH-1:0]        px;
      logic [PROD_WIDTH-1:0]        py;
      logic signed [ACC_WIDTH-1:0]  acc;
      logic [15:0]                  amp;
   } octave_carry_type;

   function automatic logic [31:0] lattice_n(input logic [31:0] x, input logic [31:0] y);
      logic [31:0] m;
      m = x + {y[25:0], 6'b0};
      return {m[18:0], 13'b0} ^ m;
   endfunction

   function automatic logic signed [31:0] noise_q30(input logic [31:0] n,
                                                    input logic [31:0] inner);
      logic [31:0] h;
      h = n * inner + HASH_ADD_C;
      return 32'sh4000_0000 - $signed({1'b0, h[30:0]});
   endfunction

   function automatic logic signed [31:0] lerp16(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input logic [15:0] f);
      logic signed [32:0] d;
      logic signed [49:0] fe;
      logic signed [49:0] p;
      d  = 33'(b) - 33'(a);
      fe = $signed({34'b0, f});
      p  = fe * 50'(d);
      return a + p[47:16];
   endfunction

   function automatic logic [7:0] blend_channel(input logic [7:0] c1, input logic [7:0] c2,
                                                input logic [T_WIDTH-1:0] t);
      logic [38:0] s;
      s = 39'(c1) * 39'(t) + 39'(c2) * 39'(ONE_Q30 - t);
      return s[37:30];
   endfunction

endpackage

FILE: hdl/cnpg_octave.sv
// One octave section: corner hashing, bilinear blend and weighted accumulation.
module cnpg_octave import cnpg_pkg::*; #(
   parameter int OCT_IDX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic [PERS_WIDTH-1:0]  cfg_persistence,
   input  logic [COUNT_WIDTH-1:0] cfg_octave_count,
   input  logic                   in_valid,
   input  octave_carry_type       in_carry,
   output logic                   out_valid,
   output octave_carry_type       out_carry
);

   localparam int SXW   = PROD_WIDTH + 16;
   localparam int DEPTH = 6;

   logic [DEPTH-1:0] valid_ff;
   octave_carry_type carry_ff [DEPTH];
   logic [15:0] fx_ff [4];
   logic [15:0] fy_ff [5];

   logic [SXW-1:0] sx, sy;
   logic [31:0] xi, yi;
   logic [31:0] n_in [4];
   logic [31:0] n_a_ff [4];
   logic [31:0] sq_b_ff [4];
   logic [31:0] n_b_ff [4];
   logic [31:0] inner_c_ff [4];
   logic [31:0] n_c_ff [4];
   logic signed [31:0] noise_d_ff [4];
   logic signed [31:0] v1_e_ff, v2_e_ff;
   logic signed [31:0] v_f_ff;

   logic signed [48:0] term_prod;
   logic signed [ACC_WIDTH-1:0] acc_in;
   logic [31:0] amp_prod;
   logic [15:0] amp_in;
   logic        oct_on;
   logic        out_valid_ff;
   octave_carry_type out_carry_ff;

   // Lattice position and fraction for this octave's doubling.
   always_comb begin
      sx = SXW'(in_carry.px) << OCT_IDX;
      sy = SXW'(in_carry.py) << OCT_IDX;
      xi = sx[47:16];
      yi = sy[47:16];
      n_in[0] = lattice_n(xi, yi);
      n_in[1] = lattice_n(xi + 32'd1, yi);
      n_in[2] = lattice_n(xi, yi + 32'd1);
      n_in[3] = lattice_n(xi + 32'd1, yi + 32'd1);
   end

   // Weight the octave value and step the amplitude.
   always_comb begin
      oct_on    = {1'b0, cfg_octave_count} > 5'(OCT_IDX);
      term_prod = 49'(v_f_ff) * $signed({33'b0, carry_ff[DEPTH-1].amp});
      acc_in    = carry_ff[DEPTH-1].acc;
      if (oct_on) begin
         acc_in = carry_ff[DEPTH-1].acc + ACC_WIDTH'($signed(term_prod[48:15]));
      end
      amp_prod = 32'(carry_ff[DEPTH-1].amp) * 32'(cfg_persistence);
      amp_in   = amp_prod[31] ? 16'hffff : amp_prod[30:15];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= {valid_ff[DEPTH-2:0], in_valid};
         out_valid_ff <= valid_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         carry_ff[0] <= in_carry;
         for (int i = 1; i < DEPTH; i++) carry_ff[i] <= carry_ff[i-1];
         fx_ff[0] <= sx[15:0];
         fy_ff[0] <= sy[15:0];
         for (int i = 1; i < 4; i++) fx_ff[i] <= fx_ff[i-1];
         for (int i = 1; i < 5; i++) fy_ff[i] <= fy_ff[i-1];
         for (int c = 0; c < 4; c++) begin
            n_a_ff[c]     <= n_in[c];
            sq_b_ff[c]    <= n_a_ff[c] * n_a_ff[c];
            n_b_ff[c]     <= n_a_ff[c];
            inner_c_ff[c] <= sq_b_ff[c] * HASH_MUL_A + HASH_ADD_B;
            n_c_ff[c]     <= n_b_ff[c];
            noise_d_ff[c] <= noise_q30(n_c_ff[c], inner_c_ff[c]);
         end
         v1_e_ff <= lerp16(noise_d_ff[0], noise_d_ff[1], fx_ff[3]);
         v2_e_ff <= lerp16(noise_d_ff[2], noise_d_ff[3], fx_ff[3]);
         v_f_ff  <= lerp16(v1_e_ff, v2_e_ff, fy_ff[4]);
         out_carry_ff.px  <= carry_ff[DEPTH-1].px;
         out_carry_ff.py  <= carry_ff[DEPTH-1].py;
         out_carry_ff.acc <= acc_in;
         out_carry_ff.amp <= amp_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_carry = out_carry_ff;

endmodule

FILE: hdl/cloud_noise_pixel_generator.sv
// Top level of the cloud noise pixel generator: registers, pipeline and output stage.
//
// Turns a pixel position (column, row) into an RGB color from a fractal sum of value
// noise. One beat is taken per clock while the pipeline is not held, and one result
// beat leaves per input beat, in order. An entry stage scales the position by the
// base frequency, each octave section has lattice setup, three hash multiply stages,
// two blend stages and a weighting stage, then a stage maps and clamps the noise sum
// and the output register blends the colors. All octave sections exist in hardware;
// octaves at or beyond octave_count pass their sum through unchanged. The pipeline
// advances whenever the output register is free or the last stage is empty, so a
// waiting result does not stop intake until it would be overwritten. Write the
// registers only while no beat is in flight.
module cloud_noise_pixel_generator import cnpg_pkg::*; #(
   parameter int MAX_OCTAVES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_data,
   input  logic                   csr_write_en,
   input  logic [2:0]             csr_index,
   input  logic [COLOR_WIDTH-1:0] csr_write_data
);

   // Configuration registers.
   logic [COLOR_WIDTH-1:0] first_color_ff, second_color_ff;
   logic [FREQ_WIDTH-1:0]  base_freq_ff;
   logic [PERS_WIDTH-1:0]  persistence_ff;
   logic [COUNT_WIDTH-1:0] octave_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_color_ff  <= 24'hffffff;
         second_color_ff <= 24'h000000;
         base_freq_ff    <= 24'h010000;
         persistence_ff  <= 16'h4000;
         octave_count_ff <= 4'd8;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            REG_FIRST_COLOR:    first_color_ff  <= csr_write_data;
            REG_SECOND_COLOR:   second_color_ff <= csr_write_data;
            REG_BASE_FREQUENCY: base_freq_ff    <= csr_write_data;
            REG_PERSISTENCE:    persistence_ff  <= csr_write_data[PERS_WIDTH-1:0];
            REG_OCTAVE_COUNT:   octave_count_ff <= csr_write_data[COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Global advance: hold only when a valid result would hit an occupied, stalled output.
   logic pipe_en;
   logic out_ready;
   logic t_valid_ff;

   assign out_ready = !rsp_valid || !rsp_stall;
   assign pipe_en   = out_ready || !t_valid_ff;
   assign req_stall = !pipe_en;

   // Entry stage: scale the position by the base frequency.
   logic             entry_valid_ff;
   octave_carry_type entry_carry_ff;
   octave_carry_type entry_carry_in;

   always_comb begin
      entry_carry_in.px  = PROD_WIDTH'(req_data.column) * PROD_WIDTH'(base_freq_ff);
      entry_carry_in.py  = PROD_WIDTH'(req_data.row) * PROD_WIDTH'(base_freq_ff);
      entry_carry_in.acc = '0;
      entry_carry_in.amp = AMP_ONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         entry_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         entry_carry_ff <= entry_carry_in;
      end
   end

   // Octave sections in a chain.
   logic             valid_chain [MAX_OCTAVES+1];
   octave_carry_type carry_chain [MAX_OCTAVES+1];

   assign valid_chain[0] = entry_valid_ff;
   assign carry_chain[0] = entry_carry_ff;

   for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_octave
      cnpg_octave #(.OCT_IDX(k)) u_octave (
         .clock            (clock),
         .reset            (reset),
         .en               (pipe_en),
         .cfg_persistence  (persistence_ff),
         .cfg_octave_count (octave_count_ff),
         .in_valid         (valid_chain[k]),
         .in_carry         (carry_chain[k]),
         .out_valid        (valid_chain[k+1]),
         .out_carry        (carry_chain[k+1])
      );
   end

   // Map the sum to t = total/2 + 1/2 and clamp to [0, 1].
   logic signed [ACC_WIDTH-1:0] t_sum;
   logic [T_WIDTH-1:0] t_in, t_ff;

   always_comb begin
      t_sum = (carry_chain[MAX_OCTAVES].acc >>> 1) + HALF_Q30;
      if (t_sum[ACC_WIDTH-1]) begin
         t_in = '0;
      end else if (t_sum > ACC_WIDTH'(ONE_Q30)) begin
         t_in = ONE_Q30;
      end else begin
         t_in = t_sum[T_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         t_valid_ff <= valid_chain[MAX_OCTAVES];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         t_ff <= t_in;
      end
   end

   // Output register: blend each channel when free.
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_data_in.blue  = blend_channel(first_color_ff[7:0], second_color_ff[7:0], t_ff);
      rsp_data_in.green = blend_channel(first_color_ff[15:8], second_color_ff[15:8], t_ff);
      rsp_data_in.red   = blend_channel(first_color_ff[23:16], second_color_ff[23:16], t_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= t_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && t_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Intake stops only behind a held result that has a successor waiting.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && t_valid_ff))
      else $error("intake stalled without a blocked result");

   // The mapped value never leaves [0, 1].
   a_t_range: assert property (@(posedge clock) disable iff (reset)
      t_valid_ff |-> (t_ff <= ONE_Q30))
      else $error("noise value out of range");

   // A held pipeline keeps its last stage.
   a_hold_last: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> ($stable(t_ff) && t_valid_ff))
      else $error("last stage changed while held");

endmodule

FILE: verif/cnpg_checker.sv
// Checker for the cloud noise pixel generator: color prediction and result comparison.
`timescale 1ns / 1ps
module cnpg_checker import cnpg_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_payload_type        req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_payload_type        rsp_data,
   input  logic                   csr_write_en,
   input  logic [2:0]             csr_index,
   input  logic [COLOR_WIDTH-1:0] csr_write_data,
   output int                     fail_count,
   output int                     pending_count
);

   localparam int MAX_OCT = 8;
   localparam logic signed [63:0] UNIT_Q30 = 64'sd1073741824;

   logic [COLOR_WIDTH-1:0] color_hi, color_lo;
   logic [FREQ_WIDTH-1:0]  freq_q16;
   logic [PERS_WIDTH-1:0]  pers_q15;
   logic [COUNT_WIDTH-1:0] octaves;
   rsp_payload_type        expected_colors[$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      fail_count++;
   endtask

   function automatic logic signed [63:0] corner_noise(input logic [31:0] xi,
                                                       input logic [31:0] yi);
      logic [31:0] m, n, inner, h;
      m     = xi + (yi << 6);
      n     = (m << 13) ^ m;
      inner = n * n * 32'd15731 + 32'd789221;
      h     = (n * inner + 32'd1376312589) & 32'h7fff_ffff;
      return UNIT_Q30 - $signed({32'd0, h});
   endfunction

   function automatic logic signed [63:0] blend16(input logic signed [63:0] a,
                                                  input logic signed [63:0] b,
                                                  input logic [15:0] f);
      logic signed [63:0] p;
      p = $signed({48'd0, f}) * (b - a);
      return a + (p >>> 16);
   endfunction

   function automatic logic [7:0] mix_channel(input logic [7:0] c1, input logic [7:0] c2,
                                              input logic signed [63:0] t);
      logic [63:0] s;
      s = 64'(c1) * 64'(t) + 64'(c2) * 64'(UNIT_Q30 - t);
      return s[37:30];
   endfunction

   function automatic rsp_payload_type predict_color(input req_payload_type p);
      logic [63:0]        fr, sx, sy, amp;
      logic [31:0]        xi, yi;
      logic signed [63:0] v1, v2, v, total, t;
      int                 count;
      rsp_payload_type    r;
      count = (octaves > MAX_OCT) ? MAX_OCT : int'(octaves);
      amp   = 64'd32768;
      total = 0;
      for (int k = 0; k < count; k++) begin
         fr = 64'(freq_q16) << k;
         sx = 64'(p.column) * fr;
         sy = 64'(p.row) * fr;
         xi = sx[47:16];
         yi = sy[47:16];
         v1 = blend16(corner_noise(xi, yi), corner_noise(xi + 32'd1, yi), sx[15:0]);
         v2 = blend16(corner_noise(xi, yi + 32'd1), corner_noise(xi + 32'd1, yi + 32'd1),
                      sx[15:0]);
         v  = blend16(v1, v2, sy[15:0]);
         total += (v * $signed(amp)) >>> 15;
         amp = (amp * 64'(pers_q15)) >> 15;
         if (amp > 64'd65535) amp = 64'd65535;
      end
      t = (total >>> 1) + (UNIT_Q30 >>> 1);
      if (t < 0) t = 0;
      if (t > UNIT_Q30) t = UNIT_Q30;
      r.blue  = mix_channel(color_hi[7:0], color_lo[7:0], t);
      r.green = mix_channel(color_hi[15:8], color_lo[15:8], t);
      r.red   = mix_channel(color_hi[23:16], color_lo[23:16], t);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         color_hi = 24'hFF_FFFF;
         color_lo = 24'h0;
         freq_q16 = 24'd65536;
         pers_q15 = 16'd16384;
         octaves  = 4'd8;
         expected_colors.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               REG_FIRST_COLOR:    color_hi = csr_write_data;
               REG_SECOND_COLOR:   color_lo = csr_write_data;
               REG_BASE_FREQUENCY: freq_q16 = csr_write_data;
               REG_PERSISTENCE:    pers_q15 = csr_write_data[PERS_WIDTH-1:0];
               REG_OCTAVE_COUNT:   octaves  = csr_write_data[COUNT_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_colors.push_back(predict_color(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_colors.size() == 0) begin
               report_mismatch("result beat with no pixel outstanding");
            end else begin
               want = expected_colors.pop_front();
               if (rsp_data.blue !== want.blue)
                  report_mismatch($sformatf("blue %0d, want %0d", rsp_data.blue, want.blue));
               if (rsp_data.green !== want.green)
                  report_mismatch($sformatf("green %0d, want %0d", rsp_data.green,
                                            want.green));
               if (rsp_data.red !== want.red)
                  report_mismatch($sformatf("red %0d, want %0d", rsp_data.red, want.red));
            end
         end
      end
      pending_count = expected_colors.size();
   end

endmodule

FILE: verif/tb_cloud_noise_pixel_generator.sv
// Testbench top for the cloud noise pixel generator: stimulus, register phases and verdict.
`timescale 1ns / 1ps
module tb_cloud_noise_pixel_generator;
   import cnpg_pkg::*;

   // Drain past the depth of the pipeline before touching registers.
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int LONG_HOLD    = 300;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_payload_type        req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_payload_type        rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [2:0]             csr_index = '0;
   logic [COLOR_WIDTH-1:0] csr_write_data = '0;
   int                     fail_count, pending_count;
   int                     cycle_count = 0;
   bit                     hold_request = 0;
   bit                     steady_sink = 0;

   cloud_noise_pixel_generator DUT (.*);
   cnpg_checker checker_i (.*);

   always #2 clock = ~clock;

   // Watchdog: give up if the run hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result side: random stall bursts, calm stretches, and on request one long hold
   // so the pipeline fills and the block stalls its input.
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (steady_sink) begin
            rsp_stall <= 1'b0;
         end else begin
            n = $urandom_range(0, 99);
            if (n < 2) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(10, 50)) @(negedge clock);
            end else begin
               rsp_stall <= (n < 30);
            end
         end
      end
   end

   // Offer one pixel beat; valid stays high into the next call unless a gap drops it.
   task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
      @(negedge clock);
      req_valid     <= 1'b1;
      req_data.column <= col;
      req_data.row    <= row;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_gap(input int n);
      if (n > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // Mostly short gaps, a few long ones, and stretches of back-to-back beats.
   task automatic random_gap();
      int n;
      n = $urandom_range(0, 99);
      if (n < 55) idle_gap(0);
      else if (n < 95) idle_gap($urandom_range(1, 3));
      else idle_gap($urandom_range(10, 40));
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [COLOR_WIDTH-1:0] value);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // Hold until every expected color has arrived, then let the pipeline empty.
   task automatic drain();
      idle_gap(1);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_all(input logic [23:0] c1, input logic [23:0] c2,
                          input logic [23:0] freq, input logic [15:0] pers,
                          input logic [3:0] count);
      write_reg(REG_FIRST_COLOR, c1);
      write_reg(REG_SECOND_COLOR, c2);
      write_reg(REG_BASE_FREQUENCY, freq);
      write_reg(REG_PERSISTENCE, 24'(pers));
      write_reg(REG_OCTAVE_COUNT, 24'(count));
   endtask

   task automatic random_pixels(input int n);
      for (int i = 0; i < n; i++) begin
         send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
         random_gap();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset settings, corner coordinates.
      send_pixel(12'd0, 12'd0);
      send_pixel(12'hFFF, 12'hFFF);
      send_pixel(12'hFFF, 12'd0);
      send_pixel(12'd0, 12'hFFF);
      send_pixel(12'hAAA, 12'h555);
      drain();

      // Zero octaves gives half; unused indices must be ignored.
      set_all(24'hFF_FFFF, 24'h00_0000, 24'hFF_FFFF, 16'hFFFF, 4'd0);
      for (int i = REG_OCTAVE_COUNT + 1; i < 8; i++) begin
         @(negedge clock);
         csr_write_en   <= 1'b1;
         csr_index      <= 3'(i);
         csr_write_data <= 24'h00_0001;
      end
      @(negedge clock);
      csr_write_en <= 1'b0;
      send_pixel(12'd123, 12'd456);
      send_pixel(12'hFFF, 12'hFFF);
      drain();

      // Count above the octave limit saturates; max frequency wraps the lattice index.
      write_reg(REG_OCTAVE_COUNT, 24'd15);
      send_pixel(12'hFFF, 12'hFFF);
      send_pixel(12'h800, 12'h7FF);
      send_pixel(12'd1, 12'd1);
      drain();

      // Single octave, zero frequency, zero persistence, inverted colors.
      set_all(24'h00_0000, 24'hFF_FFFF, 24'd0, 16'd0, 4'd1);
      send_pixel(12'd77, 12'd4000);
      drain();
      write_reg(REG_BASE_FREQUENCY, 24'd65536);
      send_pixel(12'd3, 12'd9);
      drain();
      write_reg(REG_OCTAVE_COUNT, 24'd8);
      send_pixel(12'd3, 12'd9);
      send_pixel(12'hFFF, 12'h001);
      drain();

      // Long receiver hold while the sender keeps offering beats.
      set_all(24'h12_34AB, 24'hC0_FFEE, 24'd40000, 16'd16384, 4'd8);
      hold_request = 1;
      random_pixels(90);
      drain();

      // Random phases: random settings, extremes mixed in.
      for (int ph = 0; ph < 6; ph++) begin
         set_all(24'($urandom_range(0, 24'hFF_FFFF)), 24'($urandom_range(0, 24'hFF_FFFF)),
                 (ph == 1) ? 24'hFF_FFFF : 24'($urandom_range(0, 24'hFF_FFFF)),
                 (ph == 2) ? 16'hFFFF : 16'($urandom_range(0, 16'hFFFF)),
                 (ph == 3) ? 4'd15 : 4'($urandom_range(0, 15)));
         steady_sink = (ph == 4);
         random_pixels(60);
         drain();
      end
      steady_sink = 0;

      if (fail_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/cnpg_pkg.sv
hdl/cnpg_octave.sv
hdl/cloud_noise_pixel_generator.sv
verif/cnpg_checker.sv
verif/tb_cloud_noise_pixel_generator.sv
